// ===== rtl/core/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, op codes and sizes of the two-set element store.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int CNT_W     = 6;
  localparam int RES_W     = 7;
  localparam int VAL_W     = 32;
  localparam int CQ_DEPTH  = 4;
  localparam int CQ_AW     = 2;
  localparam int OQ_DEPTH  = 4;
  localparam int OQ_AW     = 2;

  localparam logic [3:0] OP_INSERT    = 4'd0;
  localparam logic [3:0] OP_REMOVE    = 4'd1;
  localparam logic [3:0] OP_CONTAINS  = 4'd2;
  localparam logic [3:0] OP_SIZE      = 4'd3;
  localparam logic [3:0] OP_INTERSECT = 4'd4;
  localparam logic [3:0] OP_UNION     = 4'd5;
  localparam logic [3:0] OP_A_MINUS_B = 4'd6;
  localparam logic [3:0] OP_B_MINUS_A = 4'd7;
  localparam logic [3:0] OP_SUBSET    = 4'd8;

  localparam logic [2:0] K_INSERT   = 3'd0;
  localparam logic [2:0] K_REMOVE   = 3'd1;
  localparam logic [2:0] K_CONTAINS = 3'd2;
  localparam logic [2:0] K_SIZE     = 3'd3;
  localparam logic [2:0] K_SCAN     = 3'd4;
  localparam logic [2:0] K_SUBSET   = 3'd5;
  localparam logic [2:0] K_NOP      = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [2:0]              kind;
    logic                    use_b;
    logic                    outer_b;
    logic                    keep_found;
    logic                    is_union;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        position;
    logic [CNT_W-1:0]        count;
    logic                    is_subset;
    logic                    item_valid;
    logic                    last;
  } res_t;

endpackage

// ===== rtl/core/tss_front.sv =====
// ----------------------------------------------------------------------------
// tss_front
// Accepts input beats, decodes the op into a command and queues it.
// ----------------------------------------------------------------------------
module tss_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic [3:0]                       op,
  input  logic                             target_set,
  input  logic signed [tss_pkg::VAL_W-1:0] elem_value,
  output logic                             cmd_valid,
  output tss_pkg::cmd_t                    cmd,
  input  logic                             cmd_take
);

  tss_pkg::cmd_t                 cq [tss_pkg::CQ_DEPTH];
  logic [tss_pkg::CQ_AW-1:0]     wptr_r, wptr_nxt;
  logic [tss_pkg::CQ_AW-1:0]     rptr_r, rptr_nxt;
  logic [tss_pkg::CQ_AW:0]       fill_r, fill_nxt;
  tss_pkg::cmd_t                 dec;
  logic                          wr, rd;

  always_comb begin
    dec            = '0;
    dec.use_b      = target_set;
    dec.value      = elem_value;
    case (op)
      tss_pkg::OP_INSERT:   dec.kind = tss_pkg::K_INSERT;
      tss_pkg::OP_REMOVE:   dec.kind = tss_pkg::K_REMOVE;
      tss_pkg::OP_CONTAINS: dec.kind = tss_pkg::K_CONTAINS;
      tss_pkg::OP_SIZE:     dec.kind = tss_pkg::K_SIZE;
      tss_pkg::OP_INTERSECT: begin
        dec.kind       = tss_pkg::K_SCAN;
        dec.outer_b    = 1'b1;
        dec.keep_found = 1'b1;
      end
      tss_pkg::OP_UNION: begin
        dec.kind     = tss_pkg::K_SCAN;
        dec.outer_b  = 1'b1;
        dec.is_union = 1'b1;
      end
      tss_pkg::OP_A_MINUS_B: dec.kind = tss_pkg::K_SCAN;
      tss_pkg::OP_B_MINUS_A: begin
        dec.kind    = tss_pkg::K_SCAN;
        dec.outer_b = 1'b1;
      end
      // subset counts elements of b missing from a
      tss_pkg::OP_SUBSET: begin
        dec.kind    = tss_pkg::K_SUBSET;
        dec.outer_b = 1'b1;
      end
      default: dec.kind = tss_pkg::K_NOP;
    endcase
  end

  assign full      = (fill_r == (tss_pkg::CQ_AW+1)'(tss_pkg::CQ_DEPTH));
  assign cmd_valid = (fill_r != '0);
  assign cmd       = cq[rptr_r];
  assign wr        = push && !full;
  assign rd        = cmd_take && cmd_valid;

  always_comb begin
    wptr_nxt = wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = rd ? rptr_r + 1'b1 : rptr_r;
    fill_nxt = fill_r;
    if (wr && !rd) begin
      fill_nxt = fill_r + 1'b1;
    end else if (rd && !wr) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      cq[wptr_r] <= dec;
    end
  end

endmodule

// ===== rtl/core/tss_outq.sv =====
// ----------------------------------------------------------------------------
// tss_outq
// Result queue between the engine and the result ports.
// ----------------------------------------------------------------------------
module tss_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_push,
  input  tss_pkg::res_t res_in,
  output logic          res_full,
  output logic          empty,
  input  logic          pop,
  output tss_pkg::res_t res_out
);

  tss_pkg::res_t             oq [tss_pkg::OQ_DEPTH];
  logic [tss_pkg::OQ_AW-1:0] wptr_r, wptr_nxt;
  logic [tss_pkg::OQ_AW-1:0] rptr_r, rptr_nxt;
  logic [tss_pkg::OQ_AW:0]   fill_r, fill_nxt;
  logic                      wr, rd;

  assign res_full = (fill_r == (tss_pkg::OQ_AW+1)'(tss_pkg::OQ_DEPTH));
  assign empty    = (fill_r == '0);
  assign res_out  = oq[rptr_r];
  assign wr       = res_push && !res_full;
  assign rd       = pop && !empty;

  always_comb begin
    wptr_nxt = wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = rd ? rptr_r + 1'b1 : rptr_r;
    fill_nxt = fill_r;
    if (wr && !rd) begin
      fill_nxt = fill_r + 1'b1;
    end else if (rd && !wr) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      oq[wptr_r] <= res_in;
    end
  end

endmodule

// ===== rtl/core/tss_back.sv =====
// ----------------------------------------------------------------------------
// tss_back
// Execution engine: holds both element tables and runs the set operations.
// ----------------------------------------------------------------------------
module tss_back #(
  parameter int DEPTH = tss_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  tss_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          res_push,
  output tss_pkg::res_t res_data,
  input  logic          res_full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = tss_pkg::CNT_W;
  localparam int RW = tss_pkg::RES_W;
  localparam int VW = tss_pkg::VAL_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_FIND_RD  = 4'd1;
  localparam logic [3:0] S_FIND_CMP = 4'd2;
  localparam logic [3:0] S_SHIFT_RD = 4'd3;
  localparam logic [3:0] S_SHIFT_WR = 4'd4;
  localparam logic [3:0] S_NEXT     = 4'd5;
  localparam logic [3:0] S_OUT_RD   = 4'd6;
  localparam logic [3:0] S_OUT_CAP  = 4'd7;
  localparam logic [3:0] S_IN_RD    = 4'd8;
  localparam logic [3:0] S_IN_CMP   = 4'd9;
  localparam logic [3:0] S_DECIDE   = 4'd10;
  localparam logic [3:0] S_UA_NEXT  = 4'd11;
  localparam logic [3:0] S_UA_RD    = 4'd12;
  localparam logic [3:0] S_UA_EM    = 4'd13;
  localparam logic [3:0] S_REPLY    = 4'd14;

  logic signed [VW-1:0] mem_a [DEPTH];
  logic signed [VW-1:0] mem_b [DEPTH];
  logic signed [VW-1:0] rdata_a_r, rdata_b_r;

  logic [3:0]           state_r, state_nxt;
  tss_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [CW-1:0]        cnt_a_r, cnt_a_nxt;
  logic [CW-1:0]        cnt_b_r, cnt_b_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        ii_r, ii_nxt;
  logic signed [VW-1:0] ov_r, ov_nxt;
  logic                 found_r, found_nxt;
  logic                 pass_r, pass_nxt;
  logic [RW-1:0]        nres_r, nres_nxt;
  logic [RW-1:0]        emit_r, emit_nxt;
  tss_pkg::res_t        rep_r, rep_nxt;

  logic                 rd_en, rd_b, wr_en, wr_b;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic signed [VW-1:0] wr_data;

  logic [CW-1:0]        idx_inc, idx_inc2, ii_inc;
  logic [CW-1:0]        tgt_cnt, in_cnt, no_cnt, ni_cnt;
  logic signed [VW-1:0] tgt_rdata, outer_rdata, inner_rdata;
  logic                 keep;
  logic [RW-1:0]        total;

  assign idx_inc     = idx_r + 1'b1;
  assign idx_inc2    = idx_r + 2'd2;
  assign ii_inc      = ii_r + 1'b1;
  assign tgt_cnt     = cmd_r.use_b ? cnt_b_r : cnt_a_r;
  assign in_cnt      = cmd.use_b ? cnt_b_r : cnt_a_r;
  assign no_cnt      = cmd_r.outer_b ? cnt_b_r : cnt_a_r;
  assign ni_cnt      = cmd_r.outer_b ? cnt_a_r : cnt_b_r;
  assign tgt_rdata   = cmd_r.use_b ? rdata_b_r : rdata_a_r;
  assign outer_rdata = cmd_r.outer_b ? rdata_b_r : rdata_a_r;
  assign inner_rdata = cmd_r.outer_b ? rdata_a_r : rdata_b_r;
  assign keep        = cmd_r.keep_found ? found_r : !found_r;
  assign total       = nres_r + (cmd_r.is_union ? RW'(cnt_a_r) : RW'(0));

  // memory port selection, one read and one write per cycle
  always_comb begin
    rd_en   = 1'b0;
    rd_b    = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_b    = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && cmd.kind == tss_pkg::K_INSERT
            && in_cnt < CW'(DEPTH)) begin
          wr_en   = 1'b1;
          wr_b    = cmd.use_b;
          wr_addr = in_cnt[AW-1:0];
          wr_data = cmd.value;
        end
      end
      S_FIND_RD: begin
        rd_en   = 1'b1;
        rd_b    = cmd_r.use_b;
        rd_addr = idx_r[AW-1:0];
      end
      S_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_b    = cmd_r.use_b;
        rd_addr = idx_inc[AW-1:0];
      end
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_b    = cmd_r.use_b;
        wr_addr = idx_r[AW-1:0];
        wr_data = tgt_rdata;
      end
      S_OUT_RD: begin
        rd_en   = 1'b1;
        rd_b    = cmd_r.outer_b;
        rd_addr = idx_r[AW-1:0];
      end
      S_IN_RD: begin
        rd_en   = 1'b1;
        rd_b    = !cmd_r.outer_b;
        rd_addr = ii_r[AW-1:0];
      end
      S_UA_RD: begin
        rd_en   = 1'b1;
        rd_b    = 1'b0;
        rd_addr = idx_r[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en && !wr_b) begin
      mem_a[wr_addr] <= wr_data;
    end
    if (rd_en && !rd_b) begin
      rdata_a_r <= mem_a[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    if (rd_en && rd_b) begin
      rdata_b_r <= mem_b[rd_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    idx_nxt   = idx_r;
    ii_nxt    = ii_r;
    ov_nxt    = ov_r;
    found_nxt = found_r;
    pass_nxt  = pass_r;
    nres_nxt  = nres_r;
    emit_nxt  = emit_r;
    rep_nxt   = rep_r;
    cmd_take  = 1'b0;
    res_push  = 1'b0;
    res_data  = '0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take     = 1'b1;
          cmd_nxt      = cmd;
          idx_nxt      = '0;
          nres_nxt     = '0;
          emit_nxt     = '0;
          pass_nxt     = 1'b0;
          rep_nxt      = '0;
          rep_nxt.last = 1'b1;
          state_nxt    = S_REPLY;
          case (cmd.kind)
            tss_pkg::K_INSERT: begin
              if (in_cnt < CW'(DEPTH)) begin
                rep_nxt.count = in_cnt + 1'b1;
                if (cmd.use_b) begin
                  cnt_b_nxt = cnt_b_r + 1'b1;
                end else begin
                  cnt_a_nxt = cnt_a_r + 1'b1;
                end
              end else begin
                rep_nxt.status = tss_pkg::ST_FULL;
                rep_nxt.count  = in_cnt;
              end
            end
            tss_pkg::K_SIZE: rep_nxt.count = in_cnt;
            tss_pkg::K_REMOVE, tss_pkg::K_CONTAINS: begin
              if (in_cnt == '0) begin
                rep_nxt.status = tss_pkg::ST_NOTFOUND;
              end else begin
                state_nxt = S_FIND_RD;
              end
            end
            tss_pkg::K_SCAN, tss_pkg::K_SUBSET: state_nxt = S_NEXT;
            default: begin
            end
          endcase
        end
      end
      S_FIND_RD: state_nxt = S_FIND_CMP;
      S_FIND_CMP: begin
        if (tgt_rdata == cmd_r.value) begin
          if (cmd_r.kind == tss_pkg::K_REMOVE) begin
            if (idx_inc == tgt_cnt) begin
              rep_nxt.count = tgt_cnt - 1'b1;
              if (cmd_r.use_b) begin
                cnt_b_nxt = cnt_b_r - 1'b1;
              end else begin
                cnt_a_nxt = cnt_a_r - 1'b1;
              end
              state_nxt = S_REPLY;
            end else begin
              state_nxt = S_SHIFT_RD;
            end
          end else begin
            rep_nxt.position = idx_inc;
            rep_nxt.count    = tgt_cnt;
            state_nxt        = S_REPLY;
          end
        end else if (idx_inc == tgt_cnt) begin
          rep_nxt.status = tss_pkg::ST_NOTFOUND;
          rep_nxt.count  = tgt_cnt;
          state_nxt      = S_REPLY;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_FIND_RD;
        end
      end
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: begin
        idx_nxt = idx_inc;
        if (idx_inc2 == tgt_cnt) begin
          rep_nxt.count = tgt_cnt - 1'b1;
          if (cmd_r.use_b) begin
            cnt_b_nxt = cnt_b_r - 1'b1;
          end else begin
            cnt_a_nxt = cnt_a_r - 1'b1;
          end
          state_nxt = S_REPLY;
        end else begin
          state_nxt = S_SHIFT_RD;
        end
      end
      S_NEXT: begin
        if (idx_r == no_cnt) begin
          if (pass_r) begin
            state_nxt = S_IDLE;
          end else if (cmd_r.kind == tss_pkg::K_SUBSET) begin
            rep_nxt.is_subset = (nres_r == '0);
            state_nxt         = S_REPLY;
          end else if (total == '0) begin
            state_nxt = S_REPLY;
          end else begin
            nres_nxt  = total;
            pass_nxt  = 1'b1;
            idx_nxt   = '0;
            state_nxt = cmd_r.is_union ? S_UA_NEXT : S_NEXT;
          end
        end else begin
          state_nxt = S_OUT_RD;
        end
      end
      S_OUT_RD: state_nxt = S_OUT_CAP;
      S_OUT_CAP: begin
        ov_nxt    = outer_rdata;
        found_nxt = 1'b0;
        ii_nxt    = '0;
        state_nxt = (ni_cnt == '0) ? S_DECIDE : S_IN_RD;
      end
      S_IN_RD: state_nxt = S_IN_CMP;
      S_IN_CMP: begin
        if (inner_rdata == ov_r) begin
          found_nxt = 1'b1;
          state_nxt = S_DECIDE;
        end else if (ii_inc == ni_cnt) begin
          state_nxt = S_DECIDE;
        end else begin
          ii_nxt    = ii_inc;
          state_nxt = S_IN_RD;
        end
      end
      S_DECIDE: begin
        if (!pass_r) begin
          nres_nxt  = nres_r + RW'(keep);
          idx_nxt   = idx_inc;
          state_nxt = S_NEXT;
        end else if (!keep) begin
          idx_nxt   = idx_inc;
          state_nxt = S_NEXT;
        end else if (!res_full) begin
          res_push            = 1'b1;
          res_data.value      = ov_r;
          res_data.count      = nres_r[CW-1:0];
          res_data.item_valid = 1'b1;
          res_data.last       = (emit_r + 1'b1 == nres_r);
          emit_nxt            = emit_r + 1'b1;
          idx_nxt             = idx_inc;
          state_nxt           = S_NEXT;
        end
      end
      // union streams all of a before the scan of b
      S_UA_NEXT: begin
        if (idx_r == cnt_a_r) begin
          idx_nxt   = '0;
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_UA_RD;
        end
      end
      S_UA_RD: state_nxt = S_UA_EM;
      S_UA_EM: begin
        if (!res_full) begin
          res_push            = 1'b1;
          res_data.value      = rdata_a_r;
          res_data.count      = nres_r[CW-1:0];
          res_data.item_valid = 1'b1;
          res_data.last       = (emit_r + 1'b1 == nres_r);
          emit_nxt            = emit_r + 1'b1;
          idx_nxt             = idx_inc;
          state_nxt           = S_UA_NEXT;
        end
      end
      S_REPLY: begin
        if (!res_full) begin
          res_push  = 1'b1;
          res_data  = rep_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      pass_r  <= pass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    idx_r   <= idx_nxt;
    ii_r    <= ii_nxt;
    ov_r    <= ov_nxt;
    found_r <= found_nxt;
    nres_r  <= nres_nxt;
    emit_r  <= emit_nxt;
    rep_r   <= rep_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_a_r <= CW'(DEPTH) && cnt_b_r <= CW'(DEPTH))
    else $error("set count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result beat pushed into full queue");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_IDLE || state_r == S_SHIFT_WR))
    else $error("table write outside insert or shift");

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |=> (state_r != S_IDLE || $past(cmd.kind) == tss_pkg::K_NOP
                  || res_push || state_r == S_REPLY || state_nxt != S_IDLE))
    else $error("command taken without any work");
`endif

endmodule

// ===== rtl/core/two_set_store_with_set_ops_unit.sv =====
// ----------------------------------------------------------------------------
// two_set_store_with_set_ops_unit
// Two element tables with insert, remove, lookup and streamed set operations.
// ----------------------------------------------------------------------------
// Commands are queued four deep and run one at a time by the engine; results
// leave through a four-entry queue. Insert, size and unused ops go straight
// to the reply. Remove and contains scan the target table entry by entry, and
// a remove then shifts the later entries down. Set ops read the tables one
// entry at a time through a single shared read port: every outer element is
// compared with the inner elements until one matches, and the outer set is
// walked twice (a counting pass, since every result beat carries the total,
// then an emitting pass that waits while the result queue is full); subset,
// or a result with no elements, stops after the counting pass. Tables need no
// clearing after reset; only entries below the count are read.
module two_set_store_with_set_ops_unit #(
  parameter int DEPTH = tss_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [3:0]                       in_op,
  input  logic                             in_target_set,
  input  logic signed [tss_pkg::VAL_W-1:0] in_elem_value,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [1:0]                       out_status,
  output logic signed [tss_pkg::VAL_W-1:0] out_value,
  output logic [tss_pkg::CNT_W-1:0]        out_position,
  output logic [tss_pkg::CNT_W-1:0]        out_count,
  output logic                             out_is_subset,
  output logic                             out_item_valid,
  output logic                             out_last
);

  logic          cmd_valid, cmd_take, res_push, res_full;
  tss_pkg::cmd_t cmd;
  tss_pkg::res_t res_in, res_out;

  tss_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push),
    .full       (in_full),
    .op         (in_op),
    .target_set (in_target_set),
    .elem_value (in_elem_value),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  tss_back #(.DEPTH(DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_push  (res_push),
    .res_data  (res_in),
    .res_full  (res_full)
  );

  tss_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_in   (res_in),
    .res_full (res_full),
    .empty    (out_empty),
    .pop      (out_pop),
    .res_out  (res_out)
  );

  assign out_status     = res_out.status;
  assign out_value      = res_out.value;
  assign out_position   = res_out.position;
  assign out_count      = res_out.count;
  assign out_is_subset  = res_out.is_subset;
  assign out_item_valid = res_out.item_valid;
  assign out_last       = res_out.last;

endmodule
